/* hdl/rcra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcra_pkg
// Shared types, widths and reset values of the radix counter with range add.
// ----------------------------------------------------------------------------
package rcra_pkg;

  // Counter geometry
  localparam int MaxDigitsDefault = 32;
  localparam int QtyW             = 32;
  localparam int DigitW           = 8;
  localparam int RadixW           = 8;
  localparam int InitW            = 6;
  localparam int WordW            = 2 * DigitW;

  // Carry stays below 510 and a digit sum below 1019 for any stored digit
  localparam int CarryW = 9;
  localparam int SumW   = 10;

  // Register reset values
  localparam logic [RadixW-1:0] RadixReset     = 8'd10;
  localparam logic [InitW-1:0]  InitWidthReset = 6'd8;
  localparam logic [RadixW-1:0] RadixMin       = 8'd2;

  // Configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic {
    REG_RADIX      = 1'b0,
    REG_INIT_WIDTH = 1'b1
  } reg_idx_e;

  // Divider: quotient bits resolved per cycle
  localparam int DivBitsPerCycle = 8;
  localparam int DivLongCycles   = QtyW / DivBitsPerCycle;
  localparam int DivShortCycles  = 2;
  localparam int DivShortW       = DivShortCycles * DivBitsPerCycle;
  localparam int DivCntW         = $clog2(DivLongCycles);

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic              fresh;
    logic [InitW-1:0]  fresh_width;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              short_run;
    logic [QtyW-1:0]   dividend;
    logic [RadixW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QtyW-1:0]   quot;
    logic [RadixW-1:0] rem;
  } div_rsp_t;

  // Clamp a programmed width into one to max_digits
  function automatic int clamp_width(input logic [InitW-1:0] w, input int max_digits);
    int res;
    res = int'(w);
    if (res < 1) begin
      res = 1;
    end else if (res > max_digits) begin
      res = max_digits;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/rcra_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read and a write of the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module rcra_ram
  import rcra_pkg::*;
#(
  parameter int Width = WordW,
  parameter int Depth = MaxDigitsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/rcra_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcra_div
// Restoring divider by an 8-bit radix, eight quotient bits per cycle.
// Long run divides 32 bits, short run divides 16 bits.
// ----------------------------------------------------------------------------
module rcra_div
  import rcra_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [QtyW-1:0]    dvd_q;
  logic [QtyW-1:0]    dvd_nxt;
  logic [RadixW-1:0]  rem_q;
  logic [RadixW-1:0]  rem_nxt;
  logic [RadixW-1:0]  divisor_q;
  logic [RadixW:0]    part;

  // Resolve eight quotient bits; quotient shifts in from the bottom
  always_comb begin
    dvd_nxt = dvd_q;
    rem_nxt = rem_q;
    part    = '0;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      part    = {rem_nxt, dvd_nxt[QtyW-1]};
      dvd_nxt = {dvd_nxt[QtyW-2:0], 1'b0};
      if (part >= {1'b0, divisor_q}) begin
        rem_nxt    = RadixW'(part - {1'b0, divisor_q});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = part[RadixW-1:0];
      end
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_run ? DivCntW'(DivShortCycles - 1) : DivCntW'(DivLongCycles - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - DivCntW'(1);
        end
      end
    end
  end

  // Datapath; a short run starts with its operand at the top of the word
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q     <= req_i.short_run ? {req_i.dividend[DivShortW-1:0], {(QtyW-DivShortW){1'b0}}}
                                   : req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= dvd_nxt;
      rem_q <= rem_nxt;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

/* hdl/rcra_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcra_cfg
// APB register file: radix and initial width. Writing the initial width
// flags a fresh counter in the same cycle.
// ----------------------------------------------------------------------------
module rcra_cfg
  import rcra_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  logic [RadixW-1:0] radix_q;
  logic [InitW-1:0]  init_width_q;
  logic              wr_en;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RadixReset;
      init_width_q <= InitWidthReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIX:      radix_q      <= pwdata[RadixW-1:0];
        REG_INIT_WIDTH: init_width_q <= pwdata[InitW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, aligned addresses only
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_RADIX:      prdata = ApbDataW'(radix_q);
        REG_INIT_WIDTH: prdata = ApbDataW'(init_width_q);
        default:        prdata = '0;
      endcase
    end
  end

  assign cfg_o.radix       = radix_q;
  assign cfg_o.fresh       = wr_en && (reg_idx == REG_INIT_WIDTH);
  assign cfg_o.fresh_width = pwdata[InitW-1:0];

endmodule
`default_nettype wire

/* hdl/radix_counter_range_add.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow: per digit that the add touches, the shared divider runs a long pass on the
//   quantity, then a short pass on the digit sum; a zero quantity touches no digit.
// A new quantity waits until the last beat of the previous one is loaded; result beats
//   leave one per cycle while out_ready_i is high.
// Reset: the digit store reads as zero and the width is the clamped initial width;
//   writing the initial width register restores the same state at once.
// ----------------------------------------------------------------------------
// radix_counter_range_add
// Multi-digit counter in a programmable radix; each quantity is converted and
// added digit by digit, then the digits before and after are streamed out.
// ----------------------------------------------------------------------------
module radix_counter_range_add
  import rcra_pkg::*;
#(
  parameter int MaxDigits = MaxDigitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ApbAddrW-1:0]              paddr,
  input  wire logic [ApbDataW-1:0]              pwdata,
  output logic      [ApbDataW-1:0]              prdata,
  output logic                                  pready,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [QtyW-1:0]                  quantity_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [$clog2(MaxDigits)-1:0]     position_o,
  output logic      [DigitW-1:0]                start_digit_o,
  output logic      [DigitW-1:0]                end_digit_o,
  output logic      [$clog2(MaxDigits+1)-1:0]   old_width_o,
  output logic      [$clog2(MaxDigits+1)-1:0]   new_width_o,
  output logic                                  overflow_o,
  output logic                                  last_o
);

  localparam int PosW = $clog2(MaxDigits);
  localparam int CntW = $clog2(MaxDigits + 1);
  localparam logic [CntW-1:0] WidthReset = CntW'(clamp_width(InitWidthReset, MaxDigits));
  localparam logic [PosW-1:0] TopIdx     = PosW'(MaxDigits - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_QDIV = 4'b0010,
    ST_SDIV = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;
  logic [QtyW-1:0]      rem_q, rem_d;
  logic [CarryW-1:0]    carry_q, carry_d;
  logic [PosW-1:0]      k_q, k_d;
  logic [PosW-1:0]      klast_q, klast_d;
  logic                 touched_q, touched_d;
  logic                 ovf_q, ovf_d;
  logic [CntW-1:0]      old_w_q, old_w_d;
  logic [CntW-1:0]      width_q, width_d;
  logic [DigitW-1:0]    before_q, before_d;
  logic [PosW-1:0]      idx_q, idx_d;
  logic [PosW-1:0]      p_q, p_d;
  logic [MaxDigits-1:0] vld_q, vld_d;

  // RAM port and read path
  logic              ram_we;
  logic [PosW-1:0]   ram_waddr;
  logic [WordW-1:0]  ram_wdata;
  logic              ram_re;
  logic [PosW-1:0]   ram_raddr;
  logic [WordW-1:0]  ram_rdata;
  logic              rd_vld_q;
  logic              fwd_q;
  logic [WordW-1:0]  fwd_data_q;
  logic [WordW-1:0]  rd_word;
  logic [DigitW-1:0] cur_digit;
  logic [DigitW-1:0] prev_digit;
  logic [DigitW-1:0] start_sel;

  // Arithmetic helpers
  logic [RadixW-1:0] eff_radix;
  logic [SumW-1:0]   sum;
  logic [CarryW-1:0] carry_nxt;
  logic [CntW-1:0]   kp1;
  logic [CntW-1:0]   w_upd;
  logic              add_done;

  // Output register
  logic              load_out;
  logic              out_valid_q;
  logic [PosW-1:0]   position_q;
  logic [DigitW-1:0] start_q;
  logic [DigitW-1:0] end_q;
  logic [CntW-1:0]   old_width_q;
  logic [CntW-1:0]   new_width_q;
  logic              overflow_q;
  logic              last_q;

  rcra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Digit store: each word holds {digit before this item, current digit}
  rcra_ram #(
    .Width (WordW),
    .Depth (MaxDigits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_radix = (cfg.radix < RadixMin) ? RadixMin : cfg.radix;

  // Forward a write to the same entry; entries never written read as zero
  assign rd_word    = fwd_q ? fwd_data_q : ram_rdata;
  assign cur_digit  = (fwd_q || rd_vld_q) ? rd_word[DigitW-1:0] : '0;
  assign prev_digit = (fwd_q || rd_vld_q) ? rd_word[WordW-1:DigitW] : '0;
  assign start_sel  = (touched_q && (idx_q <= klast_q)) ? prev_digit : cur_digit;

  assign sum       = SumW'(cur_digit) + SumW'(div_rsp.rem) + SumW'(carry_q);
  assign carry_nxt = CarryW'(div_rsp.quot);
  assign kp1       = CntW'(k_q) + CntW'(1);
  assign w_upd     = (kp1 > width_q) ? kp1 : width_q;
  assign add_done  = (rem_q == '0) && (carry_nxt == '0);

  // Control sequencer
  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    carry_d   = carry_q;
    k_d       = k_q;
    klast_d   = klast_q;
    touched_d = touched_q;
    ovf_d     = ovf_q;
    old_w_d   = old_w_q;
    width_d   = width_q;
    before_d  = before_q;
    idx_d     = idx_q;
    p_d       = p_q;
    vld_d     = vld_q;

    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = {before_q, div_rsp.rem};
    ram_re    = 1'b0;
    ram_raddr = k_q;

    div_req.start     = 1'b0;
    div_req.short_run = 1'b0;
    div_req.dividend  = rem_q;
    div_req.divisor   = eff_radix;

    load_out = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          old_w_d = width_q;
          ovf_d   = 1'b0;
          ram_re  = 1'b1;
          if (quantity_i != '0) begin
            // Start the first digit: divide quantity, fetch digit zero
            touched_d        = 1'b1;
            rem_d            = quantity_i;
            carry_d          = '0;
            k_d              = '0;
            div_req.start    = 1'b1;
            div_req.dividend = quantity_i;
            ram_raddr        = '0;
            state_d          = ST_QDIV;
          end else begin
            // Nothing to add: go straight to the range
            touched_d = 1'b0;
            ram_raddr = PosW'(width_q - CntW'(1));
            idx_d     = PosW'(width_q - CntW'(1));
            p_d       = '0;
            state_d   = ST_EMIT;
          end
        end
      end

      ST_QDIV: begin
        // Quantity digit ready: add it to the stored digit and reduce
        if (div_rsp.done) begin
          before_d          = cur_digit;
          rem_d             = div_rsp.quot;
          div_req.start     = 1'b1;
          div_req.short_run = 1'b1;
          div_req.dividend  = QtyW'(sum);
          state_d           = ST_SDIV;
        end
      end

      ST_SDIV: begin
        // Write the reduced digit back and move on or stop
        if (div_rsp.done) begin
          ram_we     = 1'b1;
          vld_d[k_q] = 1'b1;
          carry_d    = carry_nxt;
          width_d    = w_upd;
          if (add_done || (k_q == TopIdx)) begin
            ovf_d     = !add_done;
            klast_d   = k_q;
            ram_re    = 1'b1;
            ram_raddr = PosW'(w_upd - CntW'(1));
            idx_d     = PosW'(w_upd - CntW'(1));
            p_d       = '0;
            state_d   = ST_EMIT;
          end else begin
            k_d              = k_q + PosW'(1);
            div_req.start    = 1'b1;
            div_req.dividend = rem_q;
            ram_re           = 1'b1;
            ram_raddr        = k_q + PosW'(1);
            state_d          = ST_QDIV;
          end
        end
      end

      ST_EMIT: begin
        // Stream one beat per cycle while the result register is empty or taken, most significant digit first
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_q - PosW'(1);
            p_d       = p_q + PosW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q - PosW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Fresh counter on an initial width write
    if (cfg.fresh) begin
      vld_d   = '0;
      width_d = CntW'(clamp_width(cfg.fresh_width, MaxDigits));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WidthReset;
      vld_q       <= '0;
      touched_q   <= 1'b0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      width_q   <= width_d;
      vld_q     <= vld_d;
      touched_q <= touched_d;
      ovf_q     <= ovf_d;
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
        fwd_q    <= ram_we && (ram_waddr == ram_raddr);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    carry_q  <= carry_d;
    k_q      <= k_d;
    klast_q  <= klast_d;
    old_w_q  <= old_w_d;
    before_q <= before_d;
    idx_q    <= idx_d;
    p_q      <= p_d;
    if (ram_re) begin
      fwd_data_q <= ram_wdata;
    end
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      position_q  <= p_q;
      start_q     <= start_sel;
      end_q       <= cur_digit;
      old_width_q <= old_w_q;
      new_width_q <= width_q;
      overflow_q  <= ovf_q;
      last_q      <= (idx_q == '0);
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign position_o    = position_q;
  assign start_digit_o = start_q;
  assign end_digit_o   = end_q;
  assign old_width_o   = old_width_q;
  assign new_width_o   = new_width_q;
  assign overflow_o    = overflow_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

/* tb/radix_counter_range_add_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_counter_range_add_check
// Watches the register port and both channels of the radix counter, keeps its
// own copy of the digits and compares every result beat with the beats that
// the accepted quantities should produce, oldest first.
// ----------------------------------------------------------------------------
module radix_counter_range_add_check
  import rcra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // register port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  // quantity channel
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [QtyW-1:0]     quantity_i,
  // digit channel
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [4:0]          position_i,
  input  logic [DigitW-1:0]   start_digit_i,
  input  logic [DigitW-1:0]   end_digit_i,
  input  logic [5:0]          old_width_i,
  input  logic [5:0]          new_width_i,
  input  logic                overflow_i,
  input  logic                last_i,
  // status
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int Digits      = MaxDigitsDefault;
  localparam int PosW        = $clog2(Digits);
  localparam int WidthW      = $clog2(Digits + 1);
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [DigitW-1:0] start_digit;
    logic [DigitW-1:0] end_digit;
    logic [WidthW-1:0] old_width;
    logic [WidthW-1:0] new_width;
    logic              overflow;
    logic              last;
  } digit_beat_t;

  logic [DigitW-1:0] digits_q [Digits];
  int unsigned       width_q;
  logic [RadixW-1:0] radix_q;
  digit_beat_t       expected_beats [$];
  digit_beat_t       seen_beat;
  digit_beat_t       want_beat;

  // Clear all digits and take the programmed width, clamped to the counter size
  function automatic void restart_counter(input logic [InitW-1:0] w);
    foreach (digits_q[i]) digits_q[i] = '0;
    if (w == 0) begin
      width_q = 1;
    end else if (w > Digits) begin
      width_q = Digits;
    end else begin
      width_q = w;
    end
  endfunction

  // Add one quantity into the digits and queue one beat per digit of the new width
  function automatic void add_quantity(input logic [QtyW-1:0] qty);
    logic [DigitW-1:0] prior_digits [Digits];
    int unsigned       base;
    int unsigned       rest;
    int unsigned       carry;
    int unsigned       total;
    int unsigned       k;
    int unsigned       idx;
    int unsigned       old_w;
    logic              wrapped;
    logic              done;
    digit_beat_t       beat;
    prior_digits = digits_q;
    old_w        = width_q;
    wrapped      = 1'b0;
    base         = radix_q;
    if (base < 2) begin
      base = 2;
    end
    if (qty != '0) begin
      rest  = qty;
      carry = 0;
      k     = 0;
      done  = 1'b0;
      while (!done) begin
        // widen as soon as the add reaches a digit above the width in use
        if (k + 1 > width_q) begin
          width_q = k + 1;
        end
        total       = digits_q[k] + rest % base + carry;
        digits_q[k] = DigitW'(total % base);
        carry       = total / base;
        rest        = rest / base;
        if (rest == 0 && carry == 0) begin
          done = 1'b1;
        end else if (k + 1 >= Digits) begin
          // drop what is left past the top digit
          wrapped = 1'b1;
          done    = 1'b1;
        end else begin
          k++;
        end
      end
    end
    // most significant digit first
    for (int p = 0; p < width_q; p++) begin
      idx              = width_q - 1 - p;
      beat.position    = PosW'(p);
      beat.start_digit = (idx < old_w) ? prior_digits[idx] : '0;
      beat.end_digit   = digits_q[idx];
      beat.old_width   = WidthW'(old_w);
      beat.new_width   = WidthW'(width_q);
      beat.overflow    = wrapped;
      beat.last        = (idx == 0);
      expected_beats.push_back(beat);
    end
  endfunction

  function automatic string beat_text(input digit_beat_t b);
    return $sformatf("pos=%0d start=%0d end=%0d old_w=%0d new_w=%0d ovf=%0b last=%0b",
                     b.position, b.start_digit, b.end_digit, b.old_width, b.new_width,
                     b.overflow, b.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RadixReset;
      restart_counter(InitWidthReset);
      expected_beats.delete();
      fail_count_o = 0;
    end else begin
      // track register writes
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_RADIX: begin
            radix_q = pwdata_i[RadixW-1:0];
          end
          REG_INIT_WIDTH: begin
            restart_counter(pwdata_i[InitW-1:0]);
          end
          default: begin
          end
        endcase
      end
      // predict on every accepted quantity
      if (in_valid_i && in_ready_i) begin
        add_quantity(quantity_i);
      end
      // compare every accepted digit beat with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        seen_beat = '{position_i, start_digit_i, end_digit_i, old_width_i, new_width_i,
                      overflow_i, last_i};
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit) begin
            $display("%0t: unexpected beat: %s", $realtime, beat_text(seen_beat));
          end
        end else begin
          want_beat = expected_beats.pop_front();
          if (seen_beat != want_beat) begin
            fail_count_o++;
            if (fail_count_o <= ReportLimit) begin
              $display("%0t: beat mismatch", $realtime);
              $display("  expected %s", beat_text(want_beat));
              $display("  actual   %s", beat_text(seen_beat));
            end
          end
        end
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

/* tb/radix_counter_range_add_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_counter_range_add_test
// Drives quantities and register writes into the radix counter: a directed
// pass over widening, wrapping, zero adds, clamped widths and radixes and
// digits left above a lowered radix, then random quantities under several
// random settings, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module radix_counter_range_add_test;
  import rcra_pkg::*;

  localparam int HalfPeriod    = 4;
  localparam int ResetCycles   = 12;
  localparam int CycleLimit    = 400000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 300;
  localparam int RandomPhases  = 4;
  localparam int PhaseItems    = 25;
  localparam int PosW          = $clog2(MaxDigitsDefault);
  localparam int WidthW        = $clog2(MaxDigitsDefault + 1);

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [QtyW-1:0]     quantity_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PosW-1:0]     position_o;
  logic [DigitW-1:0]   start_digit_o;
  logic [DigitW-1:0]   end_digit_o;
  logic [WidthW-1:0]   old_width_o;
  logic [WidthW-1:0]   new_width_o;
  logic                overflow_o;
  logic                last_o;

  int   fail_count;
  int   pending_beats;
  int   cycle_count;
  int   burst_left;
  logic hold_off_req;

  radix_counter_range_add uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .quantity_i    (quantity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .position_o    (position_o),
    .start_digit_o (start_digit_o),
    .end_digit_o   (end_digit_o),
    .old_width_o   (old_width_o),
    .new_width_o   (new_width_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  radix_counter_range_add_check range_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .quantity_i    (quantity_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .position_i    (position_o),
    .start_digit_i (start_digit_o),
    .end_digit_i   (end_digit_o),
    .old_width_i   (old_width_o),
    .new_width_i   (new_width_o),
    .overflow_i    (overflow_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_beats)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result sink: stall on random patterns, with long hold-offs to back up the input
  initial begin
    int mode;
    int span;
    logic held_once;
    out_ready_i = 1'b0;
    held_once   = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk_i);
        if ((hold_off_req && !held_once) || $urandom_range(0, 3999) == 0) begin
          held_once   = held_once | hold_off_req;
          out_ready_i = 1'b0;
          repeat (HoldOffCycles) @(negedge clk_i);
        end
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          2: out_ready_i = ($urandom_range(0, 3) == 0);
          default: out_ready_i = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one quantity, in bursts with random gaps between them
  task automatic send_quantity(input logic [QtyW-1:0] qty);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    quantity_i = qty;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain(input int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    drain(10);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [QtyW-1:0] pick_quantity();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      4: return 32'h1 << $urandom_range(0, 31);
      5, 6: return $urandom_range(1, 1000);
      7: return $urandom & ((32'h1 << $urandom_range(1, 31)) - 1);
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [RadixW-1:0] radix_pick;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    quantity_i   = '0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero add, carry, fill eight digits, widen past them
    send_quantity(32'd0);
    send_quantity(32'd9);
    send_quantity(32'd1);
    send_quantity(32'd99999989);
    send_quantity(32'd1);
    send_quantity(32'hFFFF_FFFF);

    // binary from one digit: grow to full width, then wrap twice
    write_reg(REG_RADIX, 32'd2);
    write_reg(REG_INIT_WIDTH, 32'd1);
    send_quantity(32'd1);
    send_quantity(32'd1);
    send_quantity(32'hFFFF_FFFF);
    send_quantity(32'hFFFF_FFFF);

    // largest radix and widest counter
    write_reg(REG_RADIX, 32'd255);
    write_reg(REG_INIT_WIDTH, 32'd32);
    send_quantity(32'hFFFF_FFFF);
    send_quantity(32'd0);
    send_quantity(32'd1);

    // lower the radix under stored digits
    write_reg(REG_RADIX, 32'd3);
    send_quantity(32'd1);
    send_quantity(32'd254);

    // radix below two and a zero width
    write_reg(REG_RADIX, 32'd0);
    write_reg(REG_INIT_WIDTH, 32'd0);
    send_quantity(32'd5);
    send_quantity(32'd1);

    // radix one and a width above the counter size: fill, then wrap to zero
    write_reg(REG_RADIX, 32'd1);
    write_reg(REG_INIT_WIDTH, 32'd63);
    send_quantity(32'hFFFF_FFFF);
    send_quantity(32'd1);
    send_quantity(32'd0);

    // random settings and quantities
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case ($urandom_range(0, 5))
        0: radix_pick = 8'd2;
        1: radix_pick = 8'd10;
        2: radix_pick = 8'd255;
        3: radix_pick = 8'd16;
        4: radix_pick = 8'd3;
        default: radix_pick = $urandom_range(0, 255);
      endcase
      write_reg(REG_RADIX, {24'd0, radix_pick});
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_INIT_WIDTH, $urandom_range(1, 32));
      end
      hold_off_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        send_quantity(pick_quantity());
      end
    end

    drain(DrainCycles);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rcra_pkg.sv
hdl/rcra_ram.sv
hdl/rcra_div.sv
hdl/rcra_cfg.sv
hdl/radix_counter_range_add.sv
tb/radix_counter_range_add_check.sv
tb/radix_counter_range_add_test.sv
